// ----- sv/xcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants of the XOR checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [7:0] HDR1_BYTE = 8'h55;
  localparam logic [7:0] HDR2_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hF0;

  localparam logic [7:0]  ADDR_RESET    = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd300;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 2;
  localparam logic [1:0] CFG_MODULE_ADDR = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd1;

  // Result kinds
  localparam logic [2:0] K_DATA    = 3'd0;
  localparam logic [2:0] K_EMPTY   = 3'd1;
  localparam logic [2:0] K_BADSUM  = 3'd2;
  localparam logic [2:0] K_BADTAIL = 3'd3;
  localparam logic [2:0] K_TIMEOUT = 3'd4;
  localparam logic [2:0] K_REJECT  = 3'd5;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       last;
  } out_item_t;

  // Command from the parser to the release side: a status kind, or K_DATA
  // with the number of buffered payload bytes to release.
  typedef struct packed {
    logic [2:0]       kind;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic queue_full;
    logic rel_pending;
  } back_status_t;

endpackage

// ----- sv/xor_checked_frame_deframer.sv -----
// An item that ends a frame writes its command into the command queue when it is accepted;
// the output register then loads its first result when the queue and that register are free.
// Throughput: one item per cycle in unless full; one payload beat per cycle out on pop.
// Input goes full when the two-entry command queue is full, or while a new frame sits in its
// payload phase before the previous frame's payload has been released from the single store.
// Reset (rst, synchronous, active high) clears the parser, queue and output register and
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Header/length/XOR-checksum frame parser on a byte and tick stream;
// reset loads the register defaults and leaves the payload store as is.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer
  import xcfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input queue side
  input  logic                 push,
  input  in_item_t             item,
  output logic                 full,
  // Result queue side
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            result,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers. The user must make writes only while the block is idle;
  // the block does not enforce it. cfg_ready is tied high; indexes past the list are dropped.
  logic [7:0]   module_address;
  logic [15:0]  timeout_ticks;

  // Front to back: one command per frame outcome, plus the store write beat.
  logic         cmd_push;
  cmd_t         cmd;
  store_wr_t    store_wr;
  back_status_t back_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_address <= ADDR_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODULE_ADDR: module_address <= cfg_data[7:0];
        CFG_TIMEOUT:     timeout_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: parse bytes and ticks, buffer payload, classify the frame.
  xcfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .item           (item),
    .full           (full),
    .module_address (module_address),
    .timeout_ticks  (timeout_ticks),
    .back_status    (back_status),
    .cmd_push       (cmd_push),
    .cmd            (cmd),
    .store_wr       (store_wr)
  );

  // Back: queue commands and drive result beats, one per cycle while results are popped.
  xcfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_push    (cmd_push),
    .cmd         (cmd),
    .store_wr    (store_wr),
    .back_status (back_status),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

// ----- sv/xcfd_front.sv -----
// ----------------------------------------------------------------------------
// xcfd_front
// Frame parser: hunts headers, checks address, length, checksum and tail,
// buffers payload and issues one command per finished or dropped frame.
// ----------------------------------------------------------------------------
module xcfd_front
  import xcfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  in_item_t     item,
  output logic         full,
  input  logic [7:0]   module_address,
  input  logic [15:0]  timeout_ticks,
  input  back_status_t back_status,
  output logic         cmd_push,
  output cmd_t         cmd,
  output store_wr_t    store_wr
);

  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CHECK = 7'b0100000,
    PH_TAIL  = 7'b1000000
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] byte_index, byte_index_next;
  logic [15:0]      tick_count, tick_count_next;
  logic             accept;
  logic [15:0]      tick_inc;
  logic [LEN_W-1:0] index_inc;

  // Full on a full queue, or in the data phase with a release pending.
  assign full   = back_status.queue_full || ((phase == PH_DATA) && back_status.rel_pending);
  assign accept = push && !full;

  assign tick_inc  = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign index_inc = byte_index + LEN_W'(1);

  always_comb begin
    phase_next        = phase;
    running_xor_next  = running_xor;
    frame_length_next = frame_length;
    byte_index_next   = byte_index;
    tick_count_next   = tick_count;
    cmd_push          = 1'b0;
    cmd               = '{kind: K_DATA, len: frame_length};
    store_wr          = '{en: 1'b0, addr: byte_index[IDX_W-1:0], data: item.rx_byte};
    if (accept) begin
      if (item.func == FUNC_TICK) begin
        if (phase inside {PH_LEN, PH_DATA, PH_CHECK, PH_TAIL}) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            cmd_push   = 1'b1;
            cmd.kind   = K_TIMEOUT;
            phase_next = PH_HUNT1;
          end
        end
      end else begin
        case (phase)
          PH_HUNT1: begin
            if (item.rx_byte == HDR1_BYTE) phase_next = PH_HUNT2;
          end
          PH_HUNT2: begin
            if (item.rx_byte == HDR2_BYTE) phase_next = PH_ADDR;
            else if (item.rx_byte != HDR1_BYTE) phase_next = PH_HUNT1;
          end
          PH_ADDR: begin
            if (item.rx_byte != module_address) begin
              cmd_push   = 1'b1;
              cmd.kind   = K_REJECT;
              phase_next = PH_HUNT1;
            end else begin
              running_xor_next = item.rx_byte;
              tick_count_next  = '0;
              phase_next       = PH_LEN;
            end
          end
          PH_LEN: begin
            if (item.rx_byte > 8'(MAX_PAYLOAD)) begin
              cmd_push   = 1'b1;
              cmd.kind   = K_REJECT;
              phase_next = PH_HUNT1;
            end else begin
              running_xor_next  = running_xor ^ item.rx_byte;
              frame_length_next = item.rx_byte[LEN_W-1:0];
              byte_index_next   = '0;
              phase_next        = (item.rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            store_wr.en      = 1'b1;
            running_xor_next = running_xor ^ item.rx_byte;
            byte_index_next  = index_inc;
            if (index_inc >= frame_length) phase_next = PH_CHECK;
          end
          PH_CHECK: begin
            running_xor_next = running_xor ^ item.rx_byte;
            phase_next       = PH_TAIL;
          end
          PH_TAIL: begin
            // Checksum outranks tail; a good empty frame gets its own status.
            cmd_push   = 1'b1;
            phase_next = PH_HUNT1;
            if (running_xor != 8'd0)          cmd.kind = K_BADSUM;
            else if (item.rx_byte != TAIL_BYTE) cmd.kind = K_BADTAIL;
            else if (frame_length == '0)      cmd.kind = K_EMPTY;
            else                              cmd.kind = K_DATA;
          end
          default: begin
            phase_next = PH_HUNT1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT1;
      running_xor  <= '0;
      frame_length <= '0;
      byte_index   <= '0;
      tick_count   <= '0;
    end else begin
      phase        <= phase_next;
      running_xor  <= running_xor_next;
      frame_length <= frame_length_next;
      byte_index   <= byte_index_next;
      tick_count   <= tick_count_next;
    end
  end

  a_no_write_over_release: assert property (@(posedge clk) disable iff (rst)
    store_wr.en |-> !back_status.rel_pending)
    else $error("payload store written while a release is pending");

  a_release_not_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.kind == K_DATA) |-> (cmd.len != '0 && cmd.len <= LEN_W'(MAX_PAYLOAD)))
    else $error("release command with bad length");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_index < frame_length))
    else $error("payload index past frame length");

endmodule

// ----- sv/xcfd_back.sv -----
// ----------------------------------------------------------------------------
// xcfd_back
// Release side: command queue, payload store and result output register.
// ----------------------------------------------------------------------------
module xcfd_back
  import xcfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_push,
  input  cmd_t         cmd,
  input  store_wr_t    store_wr,
  output back_status_t back_status,
  output logic         empty,
  input  logic         pop,
  output out_item_t    result
);

  logic [7:0]       payload_store [MAX_PAYLOAD];
  cmd_t             queue [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic [IDX_W-1:0] rel_idx;
  logic             out_valid;
  logic             load;
  logic             cmd_pop;
  cmd_t             head;
  logic             rel_last;

  assign head     = queue[rd_ptr];
  assign load     = !out_valid || pop;
  assign rel_last = (LEN_W'(rel_idx) + LEN_W'(1)) == head.len;
  assign cmd_pop  = load && (count != 2'd0) && ((head.kind != K_DATA) || rel_last);

  assign back_status.queue_full  = (count == 2'd2);
  assign back_status.rel_pending =
    ((count != 2'd0) && (queue[rd_ptr].kind == K_DATA)) ||
    ((count == 2'd2) && (queue[~rd_ptr].kind == K_DATA));

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (store_wr.en) payload_store[store_wr.addr] <= store_wr.data;
    if (cmd_push) queue[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      count     <= '0;
      rel_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_push) wr_ptr <= ~wr_ptr;
      if (cmd_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(cmd_push) - 2'(cmd_pop);
      if (load) out_valid <= (count != 2'd0);
      // Advance through the payload; rewind once the last byte is loaded.
      if (load && (count != 2'd0) && (head.kind == K_DATA)) begin
        rel_idx <= rel_last ? '0 : rel_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && (count != 2'd0)) begin
      result.kind <= head.kind;
      if (head.kind == K_DATA) begin
        result.payload_byte <= payload_store[rel_idx];
        result.last         <= rel_last;
      end else begin
        result.payload_byte <= 8'd0;
        result.last         <= 1'b1;
      end
    end
  end

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !(cmd_push && !cmd_pop))
    else $error("command queue overflow");

  a_release_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    ((count != 2'd0) && (head.kind == K_DATA)) |-> (LEN_W'(rel_idx) < head.len))
    else $error("release index past frame length");

endmodule

// ----- tb/tb_xor_checked_frame_deframer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_checked_frame_deframer
// Self-checking bench: drives byte and tick beats through the input queue,
// predicts the payload and status beats with a behavioral parser model, and
// compares every popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_deframer;
  import xcfd_pkg::*;

  // Indexes past the last real register; a write there must change nothing.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  localparam int IDLE_PCT     = 32;   // chance per cycle that a side idles
  localparam int DRAIN_CYCLES = 8;    // settle time after the last result
  localparam int RANDOM_ITEMS = 300;  // frame bytes in the random part

  // Parser phases of the behavioral model.
  typedef enum logic [6:0] {
    SEEK_SYNC1 = 7'b0000001,
    SEEK_SYNC2 = 7'b0000010,
    TAKE_ADDR  = 7'b0000100,
    TAKE_LEN   = 7'b0001000,
    TAKE_DATA  = 7'b0010000,
    TAKE_CSUM  = 7'b0100000,
    TAKE_TAIL  = 7'b1000000
  } parse_phase_e;

  logic                 clk;
  logic                 rst;
  logic                 push;
  in_item_t             item;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  out_item_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Model copy of the registers.
  logic [7:0]   addr_reg;
  logic [15:0]  timeout_reg;

  // Model copy of the parser state.
  parse_phase_e phase;
  logic [7:0]   frame_xor;
  logic [4:0]   frame_len;
  logic [4:0]   data_idx;
  logic [15:0]  ticks_seen;
  logic [7:0]   frame_store [MAX_PAYLOAD];

  out_item_t    expected_results [$];
  out_item_t    want;
  logic [7:0]   payload_q [$];   // payload of the next frame to build
  logic [7:0]   stream_q [$];    // bytes of the next stream to send
  int           mismatches;
  int           frame_bytes_sent;
  bit           no_idle;

  xor_checked_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Behavioral parser
  // --------------------------------------------------------------------------

  function automatic void clear_parser();
    addr_reg    = ADDR_RESET;
    timeout_reg = TIMEOUT_RESET;
    phase       = SEEK_SYNC1;
    frame_xor   = '0;
    frame_len   = '0;
    data_idx    = '0;
    ticks_seen  = '0;
    foreach (frame_store[i]) frame_store[i] = '0;
  endfunction

  // Any status ends the frame with a single beat and restarts the hunt.
  function automatic void end_frame(logic [2:0] kind);
    phase = SEEK_SYNC1;
    expected_results.push_back(out_item_t'{kind, 8'h00, 1'b1});
  endfunction

  function automatic void predict_beats(in_item_t it);
    if (it.func == FUNC_TICK) begin
      // Ticks only count once an address has been taken.
      if (phase inside {TAKE_LEN, TAKE_DATA, TAKE_CSUM, TAKE_TAIL}) begin
        if (ticks_seen != 16'hFFFF) ticks_seen++;
        if (ticks_seen >= timeout_reg) end_frame(K_TIMEOUT);
      end
      return;
    end
    case (phase)
      SEEK_SYNC1: begin
        if (it.rx_byte == HDR1_BYTE) phase = SEEK_SYNC2;
      end
      SEEK_SYNC2: begin
        // A repeated first header byte keeps us waiting for the second.
        if (it.rx_byte == HDR2_BYTE) phase = TAKE_ADDR;
        else if (it.rx_byte != HDR1_BYTE) phase = SEEK_SYNC1;
      end
      TAKE_ADDR: begin
        if (it.rx_byte != addr_reg) begin
          end_frame(K_REJECT);
        end else begin
          frame_xor  = it.rx_byte;
          ticks_seen = '0;
          phase      = TAKE_LEN;
        end
      end
      TAKE_LEN: begin
        if (it.rx_byte > MAX_PAYLOAD) begin
          end_frame(K_REJECT);
        end else begin
          frame_xor ^= it.rx_byte;
          frame_len  = it.rx_byte[4:0];
          data_idx   = '0;
          phase      = (it.rx_byte == 8'h00) ? TAKE_CSUM : TAKE_DATA;
        end
      end
      TAKE_DATA: begin
        frame_store[data_idx] = it.rx_byte;
        frame_xor ^= it.rx_byte;
        data_idx++;
        if (data_idx >= frame_len) phase = TAKE_CSUM;
      end
      TAKE_CSUM: begin
        frame_xor ^= it.rx_byte;
        phase      = TAKE_TAIL;
      end
      TAKE_TAIL: begin
        // Checksum outranks the tail when both are wrong.
        if (frame_xor != 8'h00) begin
          end_frame(K_BADSUM);
        end else if (it.rx_byte != TAIL_BYTE) begin
          end_frame(K_BADTAIL);
        end else if (frame_len == 0) begin
          end_frame(K_EMPTY);
        end else begin
          for (int i = 0; i < frame_len; i++)
            expected_results.push_back(
              out_item_t'{K_DATA, frame_store[i], (i == frame_len - 1)});
          phase = SEEK_SYNC1;
        end
      end
      default: phase = SEEK_SYNC1;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls and the scoreboard
  // --------------------------------------------------------------------------

  always @(posedge clk) pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);

  // Values read here are the ones sampled by this edge.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual kind=%0d byte=%02h last=%0d",
                 $time, result.kind, result.payload_byte, result.last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result.kind != want.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, result.kind);
          mismatches++;
        end
        if (result.payload_byte != want.payload_byte) begin
          $display("%0t: payload_byte mismatch, expected %02h, actual %02h",
                   $time, want.payload_byte, result.payload_byte);
          mismatches++;
        end
        if (result.last != want.last) begin
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Push one beat, with a random gap ahead of it; predict once it is taken.
  task automatic send_item(logic func, logic [7:0] b);
    in_item_t it;
    it.func    = func;
    it.rx_byte = b;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    // Keep push high straight into the next beat when there is no gap.
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_beats(it);
  endtask

  // Send stream_q as byte beats, sprinkling ticks ahead of each byte.
  task automatic send_stream(int tick_pct);
    foreach (stream_q[i]) begin
      while ($urandom_range(99) < tick_pct) send_item(FUNC_TICK, 8'($urandom_range(255)));
      send_item(FUNC_BYTE, stream_q[i]);
    end
    frame_bytes_sent += stream_q.size();
    stream_q.delete();
  endtask

  // A negative value fills with random bytes.
  function automatic void fill_payload(int n, int value);
    repeat (n) payload_q.push_back(8'((value < 0) ? $urandom_range(255) : value));
  endfunction

  // Wrap payload_q into a frame; sum_flip of zero gives a good checksum.
  task automatic send_frame(logic [7:0] addr, logic [7:0] len, logic [7:0] sum_flip,
                            logic [7:0] tail, int tick_pct);
    logic [7:0] csum;
    csum = addr ^ len ^ sum_flip;
    stream_q = '{HDR1_BYTE, HDR2_BYTE, addr, len};
    foreach (payload_q[i]) begin
      csum ^= payload_q[i];
      stream_q.push_back(payload_q[i]);
    end
    stream_q.push_back(csum);
    stream_q.push_back(tail);
    payload_q.delete();
    send_stream(tick_pct);
  endtask

  // Drop push and hold until every predicted beat is out and the pipe settles.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODULE_ADDR: addr_reg    = value[7:0];
      CFG_TIMEOUT:     timeout_reg = value;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register defaults straight out of reset; a stray tick while hunting.
  task automatic test_reset_defaults();
    send_item(FUNC_TICK, 8'hFF);
    fill_payload(1, 8'hFF);
    send_frame(ADDR_RESET, 8'd1, 8'h00, TAIL_BYTE, 0);
  endtask

  // Full-size frames at both address extremes, plus an empty frame.
  task automatic test_frame_extremes();
    write_reg(CFG_MODULE_ADDR, 16'h0000);
    fill_payload(MAX_PAYLOAD, 8'h00);
    send_frame(8'h00, 8'(MAX_PAYLOAD), 8'h00, TAIL_BYTE, 0);
    write_reg(CFG_MODULE_ADDR, 16'h00FF);
    fill_payload(MAX_PAYLOAD, 8'hFF);
    send_frame(8'hFF, 8'(MAX_PAYLOAD), 8'h00, TAIL_BYTE, 0);
    send_frame(8'hFF, 8'd0, 8'h00, TAIL_BYTE, 0);
  endtask

  // Reject, checksum and tail status paths, and the header hunt corner cases.
  task automatic test_frame_errors();
    send_frame(addr_reg ^ 8'h01, 8'd0, 8'h00, TAIL_BYTE, 0);       // wrong address
    send_frame(addr_reg, 8'(MAX_PAYLOAD + 1), 8'h00, TAIL_BYTE, 0); // length just over
    send_frame(addr_reg, 8'hFF, 8'h00, TAIL_BYTE, 0);               // length at top
    fill_payload(2, -1);
    send_frame(addr_reg, 8'd2, 8'h01, 8'h0F, 0);                    // sum and tail bad
    fill_payload(2, -1);
    send_frame(addr_reg, 8'd2, 8'h00, 8'hF1, 0);                    // tail bad only
    // Repeated first header byte, then a header broken by a foreign byte.
    stream_q = '{HDR1_BYTE, HDR1_BYTE, HDR1_BYTE, 8'h00, HDR2_BYTE};
    send_stream(0);
    fill_payload(1, -1);
    send_frame(addr_reg, 8'd1, 8'h00, TAIL_BYTE, 0);
    // A rejected address byte is consumed, so the header after it is not rescanned.
    stream_q = '{HDR1_BYTE, HDR2_BYTE, HDR1_BYTE, HDR2_BYTE, addr_reg, 8'h00,
                 addr_reg, TAIL_BYTE};
    send_stream(0);
  endtask

  // Tick timeout at zero, a small count and the top of the range.
  task automatic test_tick_timeout();
    write_reg(CFG_TIMEOUT, 16'd0);
    // A tick before the address is ignored; the first one after drops the frame.
    stream_q = '{HDR1_BYTE, HDR2_BYTE};
    send_stream(0);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_BYTE, addr_reg);
    send_item(FUNC_TICK, 8'hFF);
    write_reg(CFG_TIMEOUT, 16'd3);
    stream_q = '{HDR1_BYTE, HDR2_BYTE, addr_reg, 8'd2, 8'h5A};
    send_stream(0);
    repeat (4) send_item(FUNC_TICK, 8'($urandom_range(255)));
    // Top of the range: a frame with many ticks mixed in still gets through.
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    fill_payload(4, -1);
    send_frame(addr_reg, 8'd4, 8'h00, TAIL_BYTE, 30);
  endtask

  // Writes past the last register must leave both registers alone.
  task automatic test_spare_index();
    write_reg(CFG_SPARE_LO, 16'($urandom_range(16'hFFFF)));
    write_reg(CFG_SPARE_HI, 16'($urandom_range(16'hFFFF)));
    fill_payload(3, -1);
    send_frame(addr_reg, 8'd3, 8'h00, TAIL_BYTE, 0);
  endtask

  // Mostly good frames with random content, mixed with broken frames and noise,
  // over four register settings; the third setting runs without any idling.
  task automatic test_random_traffic();
    logic [7:0] len;
    logic [7:0] flip;
    logic [7:0] tail;
    int         pick;
    int         goal;
    int         tick_pct;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(CFG_MODULE_ADDR, 16'h0000);
          write_reg(CFG_TIMEOUT, 16'hFFFF);
          tick_pct = 10;
        end
        1: begin
          write_reg(CFG_MODULE_ADDR, 16'h00FF);
          write_reg(CFG_TIMEOUT, 16'd0);
          tick_pct = 3;
        end
        2: begin
          write_reg(CFG_MODULE_ADDR, 16'($urandom_range(255)));
          write_reg(CFG_TIMEOUT, 16'($urandom_range(4, 40)));
          tick_pct = 15;
        end
        default: begin
          write_reg(CFG_MODULE_ADDR, 16'($urandom_range(255)));
          write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 200)));
          tick_pct = 10;
        end
      endcase
      no_idle = (p == 2);
      goal = frame_bytes_sent + RANDOM_ITEMS / 4;
      while (frame_bytes_sent < goal) begin
        pick = $urandom_range(99);
        // Favor short payloads; full-size ones still show up.
        len  = 8'(($urandom_range(3) == 0) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(4));
        flip = 8'h00;
        tail = TAIL_BYTE;
        if (pick < 60) begin
          fill_payload(len, -1);
          send_frame(addr_reg, len, flip, tail, tick_pct);
        end else if (pick < 68) begin
          flip = 8'($urandom_range(1, 255));
          if ($urandom_range(1)) tail = 8'($urandom_range(255));
          fill_payload(len, -1);
          send_frame(addr_reg, len, flip, tail, tick_pct);
        end else if (pick < 74) begin
          tail = 8'($urandom_range(255));
          if (tail == TAIL_BYTE) tail = ~tail;
          fill_payload(len, -1);
          send_frame(addr_reg, len, flip, tail, tick_pct);
        end else if (pick < 80) begin
          fill_payload(len, -1);
          send_frame(addr_reg ^ 8'($urandom_range(1, 255)), len, flip, tail, tick_pct);
        end else if (pick < 86) begin
          send_frame(addr_reg, 8'($urandom_range(MAX_PAYLOAD + 1, 255)), flip, tail,
                     tick_pct);
        end else if (pick < 93) begin
          // Truncated frame: the next bytes get swallowed as payload.
          len = 8'($urandom_range(1, MAX_PAYLOAD));
          fill_payload($urandom_range(len - 1), -1);
          send_frame(addr_reg, len, flip, tail, tick_pct);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0)
              send_item(FUNC_TICK, 8'($urandom_range(255)));
            else
              send_item(FUNC_BYTE,
                        $urandom_range(1) ? HDR1_BYTE : 8'($urandom_range(255)));
          end
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    no_idle    = 1'b0;
    mismatches = 0;
    frame_bytes_sent = 0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_frame_extremes();
    test_frame_errors();
    test_tick_timeout();
    test_spare_index();
    test_random_traffic();

    // Drain, then give stray beats time to show up.
    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
